/* src/sbm_pkg.sv */
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants for the SRAM bank mapper: payloads, target
// codes, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package sbm_pkg;

   // fixed field widths
   localparam int OFFSET_W     = 15;
   localparam int DATA_W       = 8;
   localparam int TARGET_W     = 4;
   localparam int SRAM_ADDR_W  = 20;
   localparam int BANK_FIELD_W = 7;
   localparam int INPAGE_W     = 13;
   localparam int NUM_PAGES    = 4;
   localparam int PAGE_W       = 2;

   // configuration port
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 7;

   // default parameter values
   localparam int DEF_MAX_BANKS = 128;

   // reset value of the bank mask register
   localparam logic [BANK_FIELD_W-1:0] BANK_MASK_RESET = 7'h3f;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BANK_MASK    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCSI_VARIANT = 1'b1;

   // access target codes
   typedef enum logic [TARGET_W-1:0] {
      TGT_NONE    = 4'd0,
      TGT_SRAM_RD = 4'd1,
      TGT_SRAM_WR = 4'd2,
      TGT_SND_RD  = 4'd3,
      TGT_SND_WR  = 4'd4,
      TGT_DREG_RD = 4'd5,
      TGT_DREG_WR = 4'd6,
      TGT_REG_RD  = 4'd7,
      TGT_REG_WR  = 4'd8,
      TGT_CTRL    = 4'd9
   } target_type;

   // one bus access
   typedef struct packed {
      logic                cmd;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   wdata;
   } req_type;

   // one decoded access
   typedef struct packed {
      target_type             target;
      logic [SRAM_ADDR_W-1:0] sram_address;
      logic [DATA_W-1:0]      sub_address;
      logic [DATA_W-1:0]      data_out;
   } rsp_type;

   // configuration handed to the mapping unit
   typedef struct packed {
      logic [BANK_FIELD_W-1:0] bank_mask;
      logic                    scsi_variant;
   } cfg_type;

endpackage

/* src/sbm_stream_if.sv */
// ----------------------------------------------------------------------------
// sbm_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface sbm_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/scc_sram_bank_mapper_core.sv */
// ----------------------------------------------------------------------------
// scc_sram_bank_mapper_core
// Cartridge bank mapper: decodes one bus access per transfer into an SRAM,
// sound chip, SCSI or mapper register target and updates the bank state.
//
//   channel  dir  payload                                      handshake
//   req_if   in   cmd, offset, wdata                           valid/ready
//   rsp_if   out  target, sram_address, sub_address, data_out  valid/ready
//   csr_*    in   csr_index, csr_wdata                         csr_we only
//
// One access per cycle unless the result register is full and not taken;
// decode is combinational into the result register, and state written by
// an access is seen by the next one. The result is valid in the next cycle.
// req_if.ready stays high while the result register is empty or being taken.
// Synchronous reset restores the bank registers to 0..3 and clears all flags.
// ----------------------------------------------------------------------------
module scc_sram_bank_mapper_core #(
   parameter int MAX_BANKS = sbm_pkg::DEF_MAX_BANKS
) (
   input  logic                             clock,
   input  logic                             reset,
   sbm_stream_if.sink                       req_if,
   sbm_stream_if.source                     rsp_if,
   input  logic                             csr_we,
   input  logic [sbm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sbm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sbm_pkg::*;

   // configuration registers
   logic [BANK_FIELD_W-1:0] bank_mask_ff;
   logic                    scsi_variant_ff;
   cfg_type                 cfg;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type result;
   logic    accept;

   assign req_if.ready   = !rsp_valid_ff || rsp_if.ready;
   assign accept         = req_if.valid && req_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   assign cfg.bank_mask    = bank_mask_ff;
   assign cfg.scsi_variant = scsi_variant_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_mask_ff    <= BANK_MASK_RESET;
         scsi_variant_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BANK_MASK:    bank_mask_ff    <= csr_wdata;
            CSR_SCSI_VARIANT: scsi_variant_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // mapping state and decode
   sbm_map_unit #(
      .MAX_BANKS (MAX_BANKS)
   ) u_map (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_if.payload),
      .cfg    (cfg),
      .result (result)
   );

   // result register with transfer handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

endmodule

/* src/sbm_map_unit.sv */
// ----------------------------------------------------------------------------
// sbm_map_unit
// Bank and control state of the mapper with the access decode. The result
// is combinational from the request and the current state; state moves on
// at each accepted transfer.
// ----------------------------------------------------------------------------
module sbm_map_unit #(
   parameter int MAX_BANKS = sbm_pkg::DEF_MAX_BANKS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  sbm_pkg::req_type req,
   input  sbm_pkg::cfg_type cfg,
   output sbm_pkg::rsp_type result
);
   import sbm_pkg::*;

   localparam int BANK_W = $clog2(MAX_BANKS);
   localparam logic [BANK_FIELD_W-1:0] BANK_LIMIT = BANK_FIELD_W'(MAX_BANKS - 1);

   // state registers
   logic [BANK_W-1:0] bank_ff [NUM_PAGES];
   logic [BANK_W-1:0] bank_in [NUM_PAGES];
   logic              hc_we_ff, hc_we_in;   // high control bit 4
   logic              hc_hi_ff, hc_hi_in;   // high control bit 6
   logic              sram_wr_on_ff, sram_wr_on_in;
   logic              scsi_on_ff, scsi_on_in;
   logic              snd_on_ff, snd_on_in;

   // request fields
   logic [PAGE_W-1:0]       page;
   logic [INPAGE_W-1:0]     inpage;
   logic [BANK_FIELD_W-1:0] eff_mask;
   logic [BANK_FIELD_W-1:0] bank_sel;
   logic                    snd_hit;
   logic                    high_hit;
   logic                    bank_hit;

   // high control write values
   logic                    nv_we;
   logic                    nv_hi;
   logic [BANK_FIELD_W-1:0] low0;
   logic [BANK_FIELD_W-1:0] hc_bank0;

   // bank write values
   logic [BANK_FIELD_W-1:0] bw_val;
   logic [BANK_FIELD_W-1:0] bw_bank;

   assign page     = req.offset[OFFSET_W-1 -: PAGE_W];
   assign inpage   = req.offset[INPAGE_W-1:0];
   assign eff_mask = cfg.bank_mask & BANK_LIMIT;
   assign bank_sel = BANK_FIELD_W'(bank_ff[page]);

   // sound window covers offsets 0x5800 to 0x5fff
   assign snd_hit  = snd_on_ff && (req.offset[14:11] == 4'b1011);
   // high control sits at the last two bytes of page 1
   assign high_hit = (req.offset[14:1] == 14'h1fff);
   // bank registers sit in the third 2 KB slice of each page
   assign bank_hit = (req.offset[12:11] == 2'b10) && (page[1] || !sram_wr_on_ff);

   // high control write, bank 0 keeps its low six bits, masked unless SCSI mode is selected
   assign nv_we    = req.wdata[4];
   assign nv_hi    = cfg.scsi_variant & req.wdata[6];
   assign low0     = BANK_FIELD_W'(bank_ff[0]) & 7'h3f;
   assign hc_bank0 = (!nv_we && nv_hi) ? low0 : ((low0 | {nv_hi, 6'd0}) & eff_mask);

   // bank write value
   always_comb begin
      bw_val = {1'b0, req.wdata[5:0]};
      if (page == 2'd0 && !scsi_on_ff) begin
         bw_val = bw_val | {hc_hi_ff, 6'd0};
      end
      bw_bank = bw_val & eff_mask;
   end

   // decode and next state
   always_comb begin
      result.target       = TGT_NONE;
      result.sram_address = '0;
      result.sub_address  = '0;
      result.data_out     = req.cmd ? req.wdata : '0;

      for (int i = 0; i < NUM_PAGES; i++) begin
         bank_in[i] = bank_ff[i];
      end
      hc_we_in      = hc_we_ff;
      hc_hi_in      = hc_hi_ff;
      sram_wr_on_in = sram_wr_on_ff;
      scsi_on_in    = scsi_on_ff;
      snd_on_in     = snd_on_ff;

      if (scsi_on_ff && page == 2'd0) begin
         if (!inpage[12]) begin
            result.target = req.cmd ? TGT_DREG_WR : TGT_DREG_RD;
         end else begin
            result.target      = req.cmd ? TGT_REG_WR : TGT_REG_RD;
            result.sub_address = {4'd0, req.offset[3:0]};
         end
      end else if (snd_hit) begin
         result.target      = req.cmd ? TGT_SND_WR : TGT_SND_RD;
         result.sub_address = req.offset[7:0];
      end else if (!req.cmd) begin
         result.target       = TGT_SRAM_RD;
         result.sram_address = {bank_sel, inpage};
      end else if (high_hit) begin
         result.target = TGT_CTRL;
         if ({nv_we, nv_hi} != {hc_we_ff, hc_hi_ff}) begin
            hc_we_in      = nv_we;
            hc_hi_in      = nv_hi;
            sram_wr_on_in = nv_we;
            scsi_on_in    = !nv_we && nv_hi;
            bank_in[0]    = hc_bank0[BANK_W-1:0];
         end
      end else if (sram_wr_on_ff && !page[1]) begin
         result.target       = TGT_SRAM_WR;
         result.sram_address = {bank_sel, inpage};
      end else if (bank_hit) begin
         result.target = TGT_CTRL;
         if (page == 2'd2) begin
            snd_on_in = (req.wdata[5:0] == 6'h3f);
         end
         bank_in[page] = bw_bank[BANK_W-1:0];
      end
   end

   // state update on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PAGES; i++) begin
            bank_ff[i] <= BANK_W'(i);
         end
         hc_we_ff      <= 1'b0;
         hc_hi_ff      <= 1'b0;
         sram_wr_on_ff <= 1'b0;
         scsi_on_ff    <= 1'b0;
         snd_on_ff     <= 1'b0;
      end else if (accept) begin
         for (int i = 0; i < NUM_PAGES; i++) begin
            bank_ff[i] <= bank_in[i];
         end
         hc_we_ff      <= hc_we_in;
         hc_hi_ff      <= hc_hi_in;
         sram_wr_on_ff <= sram_wr_on_in;
         scsi_on_ff    <= scsi_on_in;
         snd_on_ff     <= snd_on_in;
      end
   end

endmodule
